FILE: src/rhl_pkg.sv
// Package for the RGB to HSV/HSL/luma converter: field types, constants,
// luma weight table and the reciprocal table used by the dividers.
// No dependencies.
package rhl_pkg;

  localparam int unsigned HueSector = 3840;
  localparam int unsigned HueFull   = 23040;
  localparam int unsigned LumaMax   = 65280;

  typedef enum logic [1:0] {
    WSET_SRGB  = 2'd0,
    WSET_G22   = 2'd1,
    WSET_G18   = 2'd2,
    WSET_WRAP  = 2'd3
  } wset_e;

  localparam logic [1:0] RegLumaWeightSet = 2'd0;

  typedef struct packed {
    logic [15:0] wr;
    logic [15:0] wg;
    logic [15:0] wb;
  } weights_t;

  function automatic weights_t weight_row(input logic [1:0] sel);
    weights_t w;
    case (sel)
      WSET_G22: w = '{16'd19595, 16'd38470, 16'd7471};
      WSET_G18: w = '{16'd15650, 16'd46078, 16'd4332};
      default:  w = '{16'd13933, 16'd46871, 16'd4732};
    endcase
    return w;
  endfunction

  // Reciprocal of d as ceil(2^24 / d); exact floor division for
  // numerators below 2^24 after one correction step. All divisors fit
  // in eight bits, so the table has 256 entries.
  typedef logic [24:0] recip_tab_t [256];

  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    t[0] = '0;
    for (int i = 1; i < 256; i++) begin
      t[i] = 25'((33'h1000000 + 33'(i) - 33'd1) / 33'(i));
    end
    return t;
  endfunction

  localparam recip_tab_t RecipTab = build_recip();

endpackage

FILE: src/rhl_if.sv
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing.
interface rhl_if #(parameter int W = 24) (input logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/rhl_div.sv
// Rounded divider num/den with one reciprocal multiply and correction.
// Three register stages; uses rhl_pkg. Enable stalls all stages.
module rhl_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [24:0] num_i,
  input  logic [7:0]  den_i,
  output logic [16:0] quo_o
);
  import rhl_pkg::*;

  logic [24:0] num_d, num1_q, num2_q;
  logic [7:0]  den1_q, den2_q;
  logic [24:0] rcp1_q;
  logic [49:0] prod;
  logic [24:0] q0_d, q0_q;
  logic [32:0] chk;
  logic [24:0] q_d;
  logic [16:0] quo_q;

  // The rounded quotient floor((2n+d)/(2d)) equals floor((n + floor(d/2)) / d).
  assign num_d = num_i + 25'(den_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num_d;
      den1_q <= den_i;
      rcp1_q <= RecipTab[den_i];
    end
  end

  assign prod = 50'(num1_q) * 50'(rcp1_q);
  assign q0_d = prod[48:24];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q   <= q0_d;
      num2_q <= num1_q;
      den2_q <= den1_q;
    end
  end

  assign chk = 33'(q0_q) * 33'(den2_q);
  assign q_d = (den2_q == 8'd0) ? '0 :
               ((chk > 33'(num2_q)) ? q0_q - 25'd1 : q0_q);

  always_ff @(posedge clk_i) begin
    if (en_i) quo_q <= q_d[16:0];
  end
  assign quo_o = quo_q;
endmodule

FILE: src/rgb_to_hsv_hsl_luma_core.sv
// Top level of the RGB to HSV/HSL/luma converter.
// Uses rhl_pkg, rhl_if and rhl_div.
//
// channel  | dir | payload
// pix      | in  | pixel_rgb[23:0]
// res      | out | hue, value, chroma, lightness, two saturations, luma
// apb      | in  | luma_weight_set at address 0
//
// Five register stages: one word per cycle while the result side is not stalled.
// The depth is set by the reciprocal multiply and its correction.
// rst_ni clears the valid bits and sets the weight register to WSET_G22, nothing else.
// A stall on the result side holds every stage; nothing is lost.
module rgb_to_hsv_hsl_luma_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rhl_if.sink         pix,
  rhl_if.source       res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rhl_pkg::*;

  logic [1:0] wset_q;
  logic       adv;
  logic [4:0] vld_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, wset_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wset_q <= WSET_G22;
    else if (psel && penable && pwrite && paddr == 2'd0) wset_q <= pwdata[1:0];
  end

  assign adv       = !vld_q[4] || res.ready;
  assign pix.ready = adv;
  assign res.valid = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[3:0], pix.valid};
  end

  // Stage 1: channels, extremes, hue numerator.
  logic [7:0]  r, g, b, mx, mn, c, pos, neg;
  logic [8:0]  sum, dl, kc;
  logic [2:0]  base;
  logic [24:0] hnum;
  logic [7:0]  mx1_q, c1_q;
  logic [8:0]  sum1_q, dl1_q;
  logic [24:0] hnum1_q;
  logic [7:0]  r1_q, g1_q, b1_q;

  assign r   = pix.data[23:16];
  assign g   = pix.data[15:8];
  assign b   = pix.data[7:0];
  assign mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
  assign mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
  assign c   = mx - mn;
  assign sum = {1'b0, mx} + {1'b0, mn};
  assign dl  = (sum < 9'd510 - sum) ? sum : 9'd510 - sum;

  always_comb begin
    if (r == mx)      begin base = 3'd0; pos = g; neg = b; end
    else if (g == mx) begin base = 3'd2; pos = b; neg = r; end
    else              begin base = 3'd4; pos = r; neg = g; end
    kc = 9'd0;
    if (pos >= neg) hnum = 25'(HueSector) * 25'(12'(base) * 12'(c) + 12'(pos - neg));
    else begin
      kc = 9'd0;
      hnum = 25'(HueSector) *
             25'(12'((base == 3'd0) ? 3'd6 : base) * 12'(c) - 12'(neg - pos));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx1_q <= mx; c1_q <= c; sum1_q <= sum; dl1_q <= dl + kc;
      hnum1_q <= hnum; r1_q <= r; g1_q <= g; b1_q <= b;
    end
  end

  // Stages 2-4: three dividers; luma products.
  logic [16:0] hq, sv, sl;
  rhl_div u_hue (.clk_i, .en_i(adv), .num_i(hnum1_q), .den_i(c1_q), .quo_o(hq));
  rhl_div u_shsv (.clk_i, .en_i(adv), .num_i({c1_q, 17'd0} >> 1),
                  .den_i(mx1_q), .quo_o(sv));
  rhl_div u_shsl (.clk_i, .en_i(adv), .num_i({c1_q, 17'd0} >> 1), .den_i(dl1_q[7:0]),
                  .quo_o(sl));

  weights_t w;
  logic [23:0] pr_q, pg_q, pb_q;
  logic [25:0] lsum;
  logic [17:0] lsh;
  logic [15:0] luma3_q;
  assign w = weight_row(wset_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q <= r1_q * w.wr; pg_q <= g1_q * w.wg; pb_q <= b1_q * w.wb;
    end
  end
  assign lsum = 26'(pr_q) + 26'(pg_q) + 26'(pb_q) + 26'd128;
  assign lsh  = lsum[25:8];
  always_ff @(posedge clk_i) begin
    if (adv) luma3_q <= (lsh > 18'(LumaMax)) ? 16'(LumaMax) : lsh[15:0];
  end

  // Side fields delayed to match the divider latency.
  logic [7:0]  mx2_q, c2_q, mx3_q, c3_q, mx4_q, c4_q;
  logic [8:0]  sum2_q, sum3_q, sum4_q;
  logic [15:0] luma4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx2_q <= mx1_q; c2_q <= c1_q; sum2_q <= sum1_q;
      mx3_q <= mx2_q; c3_q <= c2_q; sum3_q <= sum2_q;
      mx4_q <= mx3_q; c4_q <= c3_q; sum4_q <= sum3_q;
      luma4_q <= luma3_q;
    end
  end

  // Stage 5: output register.
  logic [14:0] hue5_q;
  logic [7:0]  mx5_q, c5_q;
  logic [8:0]  sum5_q;
  logic [16:0] sv5_q, sl5_q;
  logic [15:0] luma5_q;
  logic [16:0] hw;
  assign hw = (hq >= 17'(HueFull)) ? hq - 17'(HueFull) : hq;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue5_q <= (c4_q == 8'd0) ? 15'd0 : hw[14:0];
      mx5_q <= mx4_q; c5_q <= c4_q; sum5_q <= sum4_q;
      sv5_q <= sv; sl5_q <= sl; luma5_q <= luma4_q;
    end
  end
  assign res.data = {hue5_q, mx5_q, c5_q, sum5_q, sv5_q, sl5_q, luma5_q};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result dropped under stall");
  a_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> c5_q <= mx5_q)
    else $error("chroma above value");
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && c5_q == 8'd0 |-> hue5_q == 15'd0 && sv5_q == 17'd0)
    else $error("grey pixel with hue or saturation");
endmodule
